// ===== rtl/gri_pkg.sv =====
// ----------------------------------------------------------------------------
// gri_pkg
// Shared widths, codes, types and the display glyph table of the gear ratio
// indicator.
// ----------------------------------------------------------------------------
package gri_pkg;

    localparam int CNT_W      = 16;
    localparam int RATIO_W    = 8;
    localparam int NUM_THRESH = 5;
    localparam int PHASE_W    = 4;
    localparam int GLYPH_W    = 4;
    localparam int SEG_W      = 7;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEPS  = CNT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int SEG_E_BIT  = 4;
    localparam int RPM_SHIFT  = 4;

    typedef logic [PHASE_W-1:0]                    phase_t;
    typedef logic [GLYPH_W-1:0]                    glyph_t;
    typedef logic [STAT_W-1:0]                     status_t;
    typedef logic [RATIO_W-1:0]                    ratio_t;
    typedef logic [NUM_THRESH-1:0][RATIO_W-1:0]    thresh_vec_t;

    localparam phase_t PHASE_FIRST  = 4'd1;
    localparam phase_t PHASE_SECOND = 4'd2;
    localparam phase_t PHASE_TOP    = 4'd6;
    localparam phase_t PHASE_MERGE  = 4'd7;
    localparam phase_t PHASE_IDLE   = 4'd8;
    localparam phase_t PHASE_DONE   = 4'd15;

    localparam glyph_t GLYPH_ZERO  = 4'd0;
    localparam glyph_t GLYPH_FIRST = 4'd1;
    localparam glyph_t GLYPH_EIGHT = 4'd8;
    localparam glyph_t GLYPH_N     = 4'd10;
    localparam glyph_t GLYPH_L     = 4'd11;
    localparam glyph_t GLYPH_DASH  = 4'd12;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_SPEED_OVF = 2'd1;
    localparam status_t STAT_RPM_OVF   = 2'd2;

    localparam thresh_vec_t THRESH_RESET = {8'h15, 8'h18, 8'h1A, 8'h1E, 8'h24};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } dp_cmd_t;

    function automatic logic [SEG_W-1:0] glyph_seg(glyph_t g);
        logic [SEG_W-1:0] s;
        unique case (g)
            4'd0:       s = 7'h3F;
            4'd1:       s = 7'h06;
            4'd2:       s = 7'h5B;
            4'd3:       s = 7'h4F;
            4'd4:       s = 7'h66;
            4'd5:       s = 7'h6D;
            4'd6:       s = 7'h7D;
            4'd7:       s = 7'h07;
            4'd8:       s = 7'h7F;
            4'd9:       s = 7'h67;
            GLYPH_N:    s = 7'h54;
            GLYPH_L:    s = 7'h38;
            GLYPH_DASH: s = 7'h40;
            default:    s = 7'h3F;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/gri_ctrl.sv =====
// ----------------------------------------------------------------------------
// gri_ctrl
// Sequencer: takes a word, runs the divider for a fixed number of steps,
// then commits the result into the output register when it is free.
// ----------------------------------------------------------------------------
module gri_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              cfg_ready,
    output gri_pkg::dp_cmd_t  cmd
);

    gri_pkg::ctrl_state_t              state_reg;
    gri_pkg::ctrl_state_t              state_next;
    logic [gri_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [gri_pkg::DIV_CNT_W-1:0]     cnt_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              slot_free;
    logic                              last_step;

    assign slot_free = !out_valid_reg || !out_stall;
    assign last_step = (cnt_reg == gri_pkg::DIV_CNT_W'(gri_pkg::DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gri_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gri_pkg::ST_DIVIDE;
                end
            end
            gri_pkg::ST_DIVIDE:
            begin
                if (last_step)
                begin
                    state_next = gri_pkg::ST_FINISH;
                end
            end
            gri_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = gri_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gri_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.commit     = 1'b0;
        cnt_next       = cnt_reg;
        in_stall       = 1'b1;
        cfg_ready      = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            gri_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                cfg_ready = 1'b1;
                cnt_next  = '0;
                cmd.load  = in_valid;
            end
            gri_pkg::ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            gri_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gri_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/gri_dp.sv =====
// ----------------------------------------------------------------------------
// gri_dp
// Datapath: word capture, restoring divider, calibration state, gear
// classification and the output register.
// ----------------------------------------------------------------------------
module gri_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gri_pkg::dp_cmd_t                    cmd,
    input  logic                                neutral,
    input  logic                                clutch,
    input  logic                                setup_switch,
    input  logic [gri_pkg::CNT_W-1:0]           rpm_count,
    input  logic [gri_pkg::CNT_W-1:0]           speed_count,
    input  logic                                rpm_overflow,
    input  logic                                speed_overflow,
    input  logic                                cfg_we,
    input  logic [gri_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gri_pkg::RATIO_W-1:0]         cfg_data,
    output logic [gri_pkg::SEG_W-1:0]           segments,
    output logic                                seg_e,
    output logic [gri_pkg::RATIO_W-1:0]         gear_ratio,
    output logic [gri_pkg::STAT_W-1:0]          measure_status,
    output logic                                store_request,
    output gri_pkg::thresh_vec_t                thresh
);

    localparam int CW = gri_pkg::CNT_W;

    // captured word
    logic                   neutral_reg;
    logic                   clutch_reg;
    logic                   setup_reg;
    logic                   rpm_ovf_reg;
    logic                   spd_ovf_reg;
    logic                   rpm_zero_reg;
    logic [CW-1:0]          spd_reg;

    // divider
    logic [CW-1:0]          rem_reg;
    logic [CW-1:0]          quo_reg;
    logic [CW:0]            rem_sh;
    logic [CW:0]            rem_diff;
    logic                   rem_ge;

    // calibration state
    gri_pkg::thresh_vec_t   thr_reg;
    gri_pkg::ratio_t        top_reg;
    gri_pkg::phase_t        phase_reg;

    // commit values
    gri_pkg::thresh_vec_t   thr_upd;
    gri_pkg::thresh_vec_t   thr_mid;
    gri_pkg::ratio_t        top_upd;
    gri_pkg::phase_t        phase_upd;
    gri_pkg::glyph_t        glyph;
    gri_pkg::glyph_t        gear;
    gri_pkg::ratio_t        ratio_o;
    gri_pkg::status_t       stat_o;
    gri_pkg::ratio_t        meas_ratio;
    gri_pkg::status_t       meas_stat;
    logic                   store_o;
    logic                   do_cls;
    logic [8:0]             mid_sum [gri_pkg::NUM_THRESH];
    logic [gri_pkg::SEG_W-1:0] seg_w;

    assign rem_sh   = {rem_reg, quo_reg[CW-1]};
    assign rem_diff = rem_sh - {1'b0, spd_reg};
    assign rem_ge   = (rem_sh >= {1'b0, spd_reg});

    always_comb
    begin
        if (spd_ovf_reg)
        begin
            meas_stat  = gri_pkg::STAT_SPEED_OVF;
            meas_ratio = '0;
        end
        else if (rpm_ovf_reg)
        begin
            meas_stat  = gri_pkg::STAT_RPM_OVF;
            meas_ratio = '0;
        end
        else
        begin
            meas_stat  = gri_pkg::STAT_OK;
            meas_ratio = (rpm_zero_reg || spd_reg == '0) ? '0 : quo_reg[gri_pkg::RATIO_W-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < gri_pkg::NUM_THRESH; k++)
        begin
            if (k < gri_pkg::NUM_THRESH - 1)
            begin
                mid_sum[k] = {1'b0, thr_reg[k]} + {1'b0, thr_reg[k+1]};
            end
            else
            begin
                mid_sum[k] = {1'b0, thr_reg[k]} + {1'b0, top_reg};
            end
            thr_mid[k] = mid_sum[k][8:1];
        end
    end

    always_comb
    begin
        thr_upd   = thr_reg;
        top_upd   = top_reg;
        phase_upd = phase_reg;
        glyph     = gri_pkg::GLYPH_ZERO;
        ratio_o   = '0;
        stat_o    = gri_pkg::STAT_OK;
        store_o   = 1'b0;
        do_cls    = 1'b0;
        if (neutral_reg)
        begin
            if (setup_reg)
            begin
                if (phase_reg != gri_pkg::PHASE_FIRST && phase_reg != gri_pkg::PHASE_SECOND)
                begin
                    phase_upd = gri_pkg::PHASE_FIRST;
                end
                glyph = gri_pkg::GLYPH_L;
            end
            else
            begin
                glyph = gri_pkg::GLYPH_N;
            end
        end
        else if (clutch_reg)
        begin
            glyph = gri_pkg::GLYPH_DASH;
        end
        else if (setup_reg)
        begin
            if (phase_reg >= gri_pkg::PHASE_FIRST && phase_reg <= gri_pkg::PHASE_TOP)
            begin
                ratio_o = meas_ratio;
                stat_o  = meas_stat;
                if (phase_reg == gri_pkg::PHASE_TOP)
                begin
                    top_upd = meas_ratio;
                end
                else
                begin
                    thr_upd[phase_reg[gri_pkg::CFG_IDX_W-1:0] - 1'b1] = meas_ratio;
                end
                phase_upd = phase_reg + 1'b1;
                glyph     = phase_upd;
            end
            else if (phase_reg == gri_pkg::PHASE_MERGE)
            begin
                thr_upd   = thr_mid;
                phase_upd = gri_pkg::PHASE_DONE;
                store_o   = 1'b1;
                do_cls    = 1'b1;
            end
            else if (phase_reg == gri_pkg::PHASE_DONE)
            begin
                do_cls = 1'b1;
            end
            else
            begin
                glyph = gri_pkg::GLYPH_EIGHT;
            end
        end
        else
        begin
            do_cls = 1'b1;
        end

        priority if (meas_ratio == '0)
            gear = gri_pkg::GLYPH_ZERO;
        else if (meas_ratio < thr_upd[4])
            gear = 4'd6;
        else if (meas_ratio < thr_upd[3])
            gear = 4'd5;
        else if (meas_ratio < thr_upd[2])
            gear = 4'd4;
        else if (meas_ratio < thr_upd[1])
            gear = 4'd3;
        else if (meas_ratio < thr_upd[0])
            gear = 4'd2;
        else
            gear = gri_pkg::GLYPH_FIRST;

        if (do_cls)
        begin
            ratio_o = meas_ratio;
            stat_o  = meas_stat;
            glyph   = gear;
        end
    end

    assign seg_w = gri_pkg::glyph_seg(glyph);

    // word capture and divider
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neutral_reg  <= neutral;
            clutch_reg   <= clutch;
            setup_reg    <= setup_switch;
            rpm_ovf_reg  <= rpm_overflow;
            spd_ovf_reg  <= speed_overflow;
            rpm_zero_reg <= (rpm_count[CW-gri_pkg::RPM_SHIFT-1:0] == '0);
            spd_reg      <= speed_count;
            rem_reg      <= '0;
            quo_reg      <= {rpm_count[CW-gri_pkg::RPM_SHIFT-1:0], {gri_pkg::RPM_SHIFT{1'b0}}};
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
            quo_reg <= {quo_reg[CW-2:0], rem_ge};
        end
    end

    // calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= gri_pkg::THRESH_RESET;
            top_reg   <= '0;
            phase_reg <= gri_pkg::PHASE_IDLE;
        end
        else if (cmd.commit)
        begin
            thr_reg   <= thr_upd;
            top_reg   <= top_upd;
            phase_reg <= phase_upd;
        end
        else if (cfg_we && cfg_index < gri_pkg::CFG_IDX_W'(gri_pkg::NUM_THRESH))
        begin
            thr_reg[cfg_index] <= cfg_data;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            segments       <= seg_w;
            seg_e          <= seg_w[gri_pkg::SEG_E_BIT];
            gear_ratio     <= ratio_o;
            measure_status <= stat_o;
            store_request  <= store_o;
        end
    end

    assign thresh = thr_reg;

endmodule

// ===== rtl/gear_ratio_indicator_unit.sv =====
// ----------------------------------------------------------------------------
// gear_ratio_indicator_unit
// Gear indicator: one measurement window in, one display word out.
//
// Input channel (in_valid / in_stall): one word per measurement window with
// the switch states and the engine and wheel pulse counts. The unit stalls
// the input while a word is in progress.
// Output channel (out_valid / out_stall): seven-segment pattern, ratio,
// overflow status, store request and the working thresholds after the word.
// Config channel (cfg_valid / cfg_ready): index 0..4 loads saved threshold
// two..six into the working set; other indexes are dropped. Ready only idle.
// Timing: the word is captured at accept, then the radix-2 restoring divider
// runs its steps, then the commit loads the output register and raises
// out_valid. The next word is taken in the cycle after commit, so a word is
// not accepted before the previous one is committed.
// Stall: a result waits in the output register; the next word is accepted
// and divided, and its commit holds until the waiting result is taken.
// Reset: thresholds return to their boot values, calibration goes to idle
// (phase 8), top gear ratio to zero, no output valid.
// ----------------------------------------------------------------------------
module gear_ratio_indicator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                neutral,
    input  logic                                clutch,
    input  logic                                setup_switch,
    input  logic [gri_pkg::CNT_W-1:0]           rpm_count,
    input  logic [gri_pkg::CNT_W-1:0]           speed_count,
    input  logic                                rpm_overflow,
    input  logic                                speed_overflow,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [gri_pkg::SEG_W-1:0]           segments,
    output logic                                seg_e,
    output logic [gri_pkg::RATIO_W-1:0]         gear_ratio,
    output logic [gri_pkg::STAT_W-1:0]          measure_status,
    output logic                                store_request,
    output logic [gri_pkg::RATIO_W-1:0]         new_thresh_2,
    output logic [gri_pkg::RATIO_W-1:0]         new_thresh_3,
    output logic [gri_pkg::RATIO_W-1:0]         new_thresh_4,
    output logic [gri_pkg::RATIO_W-1:0]         new_thresh_5,
    output logic [gri_pkg::RATIO_W-1:0]         new_thresh_6,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gri_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gri_pkg::RATIO_W-1:0]         cfg_data
);

    gri_pkg::dp_cmd_t       cmd;
    gri_pkg::thresh_vec_t   thresh;
    logic                   cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    gri_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    gri_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .neutral        (neutral),
        .clutch         (clutch),
        .setup_switch   (setup_switch),
        .rpm_count      (rpm_count),
        .speed_count    (speed_count),
        .rpm_overflow   (rpm_overflow),
        .speed_overflow (speed_overflow),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .segments       (segments),
        .seg_e          (seg_e),
        .gear_ratio     (gear_ratio),
        .measure_status (measure_status),
        .store_request  (store_request),
        .thresh         (thresh)
    );

    assign new_thresh_2 = thresh[0];
    assign new_thresh_3 = thresh[1];
    assign new_thresh_4 = thresh[2];
    assign new_thresh_5 = thresh[3];
    assign new_thresh_6 = thresh[4];

endmodule
